FILE: rtl/spid_pkg.sv
// ----------------------------------------------------------------------------
// spid_pkg: shared definitions for the speed PID controller
// Action codes, register indexes, sequencer states and small arithmetic
// helpers used by the controller core.
// ----------------------------------------------------------------------------
package spid_pkg;

    localparam int ADDR_W = 5;

    // action codes carried by an input transfer
    localparam logic [1:0] ACT_SET     = 2'd0;
    localparam logic [1:0] ACT_COMPUTE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_FF_GAIN       = 3'd3;
    localparam logic [2:0] REG_DEAD_BAND     = 3'd4;
    localparam logic [2:0] REG_SUM_LIMIT     = 3'd5;
    localparam logic [2:0] REG_CMD_LOW       = 3'd6;
    localparam logic [2:0] REG_CMD_HIGH      = 3'd7;

    localparam logic [31:0] TIMEOUT_US = 32'd500000;
    localparam logic [31:0] MICRO      = 32'd1000000;
    localparam logic [63:0] TERM_CAP   = 64'h1000_0000_0000_0000;

    // last count of the shift-add multiplier and the restoring divider
    localparam logic [6:0] MUL_LAST = 7'd31;
    localparam logic [6:0] DIV_LAST = 7'd95;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FF,
        ST_EVAL,
        ST_P,
        ST_D1,
        ST_D2,
        ST_DDIV,
        ST_I1,
        ST_I2,
        ST_IDIV,
        ST_CMD,
        ST_FIN
    } state_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] m, input logic neg);
        return neg ? (~m + 64'd1) : m;
    endfunction

    // limit a quotient to the term cap
    function automatic logic [63:0] cap_term(input logic [95:0] q);
        return (|q[95:60]) ? TERM_CAP : {4'b0, q[59:0]};
    endfunction

endpackage

FILE: rtl/spid_in_if.sv
// ----------------------------------------------------------------------------
// spid_in_if: input channel of the speed PID controller
// Valid/ready channel carrying one action item per transfer.
// ----------------------------------------------------------------------------
interface spid_in_if;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] target_value;
    logic signed [31:0] measured_speed;
    logic [31:0]        now_us;

    modport source (
        output valid, action, target_value, measured_speed, now_us,
        input  ready
    );

    modport sink (
        input  valid, action, target_value, measured_speed, now_us,
        output ready
    );

endinterface

FILE: rtl/spid_out_if.sv
// ----------------------------------------------------------------------------
// spid_out_if: result channel of the speed PID controller
// Valid/ready channel carrying one drive command per transfer.
// ----------------------------------------------------------------------------
interface spid_out_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] command;
    logic               expired;

    modport source (
        output valid, command, expired,
        input  ready
    );

    modport sink (
        input  valid, command, expired,
        output ready
    );

endinterface

FILE: rtl/speed_pid_with_timeout_core.sv
// ----------------------------------------------------------------------------
// speed_pid_with_timeout_core: speed PID with feedforward and command timeout
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      action, target_value, measured_speed, now_us
//   out_ch    out   valid/ready      command, expired (compute items only)
//   apb       in    psel/penable     8 registers at 4*i, pready always high
//
// One item at a time. A clear item is handled in the idle state, a set-target
// item runs a 32-step shift-add multiply for the feedforward term. A compute
// item skips the terms on timeout, zero time step or dead band, else runs P, plus
// the derivative and the integral term, each when its gain is nonzero (two 32-step multiplies
// and a 96-step restoring divide each, all on one shared serial unit).
// Reset is asynchronous; all controller state clears to zero. The input is
// taken again while a finished result still waits in the output register; a
// new result holds in the final step until that register is free.
// ----------------------------------------------------------------------------
module speed_pid_with_timeout_core (
    input  logic                       clk,
    input  logic                       rst_n,
    spid_in_if.sink                    in_ch,
    spid_out_if.source                 out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spid_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import spid_pkg::*;

    // configuration
    logic [31:0] prop_gain_reg, integral_gain_reg, deriv_gain_reg, ff_gain_reg;
    logic [30:0] dead_band_reg, sum_limit_reg;
    logic [15:0] cmd_low_reg, cmd_high_reg;

    // controller state
    state_t      state_reg, state_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] ff_term_reg, ff_term_next;
    logic [31:0] err_accum_reg, err_accum_next;
    logic [32:0] last_error_reg, last_error_next;
    logic [31:0] setpoint_stamp_reg, setpoint_stamp_next;
    logic [31:0] update_stamp_reg, update_stamp_next;
    logic [15:0] last_command_reg, last_command_next;
    logic        expired_reg, expired_next;

    // item work registers
    logic [31:0] meas_reg, meas_next;
    logic [31:0] now_reg, now_next;
    logic [32:0] error_reg, error_next;
    logic [31:0] dt_reg, dt_next;
    logic [63:0] sum_reg, sum_next;
    logic        term_neg_reg, term_neg_next;
    logic [15:0] res_cmd_reg, res_cmd_next;

    // serial multiply / divide unit
    logic [95:0] acc_reg, acc_next;
    logic [95:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] divisor_reg, divisor_next;
    logic [6:0]  cnt_reg, cnt_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_cmd_reg, out_cmd_next;
    logic        out_to_reg, out_to_next;

    logic        in_fire, cfg_write, out_free;
    logic        is_mul, is_div, unit_last;
    logic [95:0] mul_sum, div_q;
    logic [32:0] div_shift, div_rem;
    logic        div_ge;
    logic [32:0] err_now, err_mag;
    logic [33:0] derr, derr_mag;
    logic [31:0] tgt_mag, elapsed, dt_now;
    logic        timeout_hit, in_dead;
    logic [79:0] ff_prod;
    logic [31:0] ff_sat;
    logic [63:0] div_term;
    logic [33:0] new_acc, lim_pos, lim_neg, acc_clamped;
    logic [63:0] total, hi_q, lo_q, total_adj;
    logic [15:0] cmd_final;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= 32'd65536;
            integral_gain_reg <= '0;
            deriv_gain_reg    <= '0;
            ff_gain_reg       <= '0;
            dead_band_reg     <= '0;
            sum_limit_reg     <= '0;
            cmd_low_reg       <= 16'hFF01;
            cmd_high_reg      <= 16'd255;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_PROP_GAIN:     prop_gain_reg     <= pwdata;
                REG_INTEGRAL_GAIN: integral_gain_reg <= pwdata;
                REG_DERIV_GAIN:    deriv_gain_reg    <= pwdata;
                REG_FF_GAIN:       ff_gain_reg       <= pwdata;
                REG_DEAD_BAND:     dead_band_reg     <= pwdata[30:0];
                REG_SUM_LIMIT:     sum_limit_reg     <= pwdata[30:0];
                REG_CMD_LOW:       cmd_low_reg       <= pwdata[15:0];
                REG_CMD_HIGH:      cmd_high_reg      <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_PROP_GAIN:     prdata = prop_gain_reg;
            REG_INTEGRAL_GAIN: prdata = integral_gain_reg;
            REG_DERIV_GAIN:    prdata = deriv_gain_reg;
            REG_FF_GAIN:       prdata = ff_gain_reg;
            REG_DEAD_BAND:     prdata = {1'b0, dead_band_reg};
            REG_SUM_LIMIT:     prdata = {1'b0, sum_limit_reg};
            REG_CMD_LOW:       prdata = {{16{cmd_low_reg[15]}}, cmd_low_reg};
            REG_CMD_HIGH:      prdata = {{16{cmd_high_reg[15]}}, cmd_high_reg};
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // arithmetic
    // ------------------------------------------------------------------
    assign is_mul = (state_reg == ST_FF) || (state_reg == ST_P) ||
                    (state_reg == ST_D1) || (state_reg == ST_D2) ||
                    (state_reg == ST_I1) || (state_reg == ST_I2);
    assign is_div = (state_reg == ST_DDIV) || (state_reg == ST_IDIV);
    assign unit_last = is_mul ? (cnt_reg == MUL_LAST) : (cnt_reg == DIV_LAST);

    // one multiplier bit per cycle
    assign mul_sum = acc_reg + (mplier_reg[0] ? mcand_reg : 96'd0);

    // one quotient bit per cycle
    assign div_shift = {rem_reg[31:0], acc_reg[95]};
    assign div_ge    = div_shift >= {1'b0, divisor_reg};
    assign div_rem   = div_ge ? (div_shift - {1'b0, divisor_reg}) : div_shift;
    assign div_q     = {acc_reg[94:0], div_ge};
    assign div_term  = cap_term(div_q);

    assign err_now  = {target_reg[31], target_reg} - {meas_reg[31], meas_reg};
    assign err_mag  = err_now[32] ? (~err_now + 33'd1) : err_now;
    assign derr     = {error_reg[32], error_reg} - {last_error_reg[32], last_error_reg};
    assign derr_mag = derr[33] ? (~derr + 34'd1) : derr;
    assign tgt_mag  = mag32(target_reg);
    assign elapsed  = now_reg - setpoint_stamp_reg;
    assign dt_now   = now_reg - update_stamp_reg;
    assign timeout_hit = !expired_reg && (elapsed > TIMEOUT_US);
    assign in_dead  = tgt_mag < {1'b0, dead_band_reg};

    // feedforward: saturate to the signed 32-bit range
    assign ff_prod = mul_sum[95:16];
    always_comb
    begin
        if (|ff_prod[79:31])
            ff_sat = term_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            ff_sat = term_neg_reg ? (~ff_prod[31:0] + 32'd1) : ff_prod[31:0];
    end

    // integral accumulator with clamp
    assign new_acc     = {{2{err_accum_reg[31]}}, err_accum_reg} + {error_reg[32], error_reg};
    assign lim_pos     = {3'b0, sum_limit_reg};
    assign lim_neg     = ~lim_pos + 34'd1;
    assign acc_clamped = ($signed(new_acc) > $signed(lim_pos)) ? lim_pos :
                         ($signed(new_acc) < $signed(lim_neg)) ? lim_neg : new_acc;

    // command limits
    assign total     = sum_reg + {{32{ff_term_reg[31]}}, ff_term_reg};
    assign hi_q      = {{32{cmd_high_reg[15]}}, cmd_high_reg, 16'b0};
    assign lo_q      = {{32{cmd_low_reg[15]}}, cmd_low_reg, 16'b0};
    assign total_adj = total + (total[63] ? 64'h0000_0000_0000_FFFF : 64'd0);
    assign cmd_final = ($signed(total) > $signed(hi_q)) ? cmd_high_reg :
                       ($signed(total) < $signed(lo_q)) ? cmd_low_reg : total_adj[31:16];

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_ch.action == ACT_SET)
                    state_next = ST_FF;
                else if (in_fire && in_ch.action == ACT_COMPUTE)
                    state_next = ST_EVAL;
            end
            ST_FF:
            begin
                if (unit_last)
                    state_next = ST_IDLE;
            end
            ST_EVAL:
            begin
                if (timeout_hit || dt_now == 32'd0 || in_dead)
                    state_next = ST_FIN;
                else
                    state_next = ST_P;
            end
            ST_P:
            begin
                if (unit_last)
                begin
                    if (deriv_gain_reg != 32'd0)
                        state_next = ST_D1;
                    else if (integral_gain_reg != 32'd0)
                        state_next = ST_I1;
                    else
                        state_next = ST_CMD;
                end
            end
            ST_D1:   if (unit_last) state_next = ST_D2;
            ST_D2:   if (unit_last) state_next = ST_DDIV;
            ST_DDIV:
            begin
                if (unit_last)
                    state_next = (integral_gain_reg != 32'd0) ? ST_I1 : ST_CMD;
            end
            ST_I1:   if (unit_last) state_next = ST_I2;
            ST_I2:   if (unit_last) state_next = ST_IDIV;
            ST_IDIV: if (unit_last) state_next = ST_CMD;
            ST_CMD:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        target_next         = target_reg;
        ff_term_next        = ff_term_reg;
        err_accum_next      = err_accum_reg;
        last_error_next     = last_error_reg;
        setpoint_stamp_next = setpoint_stamp_reg;
        update_stamp_next   = update_stamp_reg;
        last_command_next   = last_command_reg;
        expired_next        = expired_reg;
        meas_next           = meas_reg;
        now_next            = now_reg;
        error_next          = error_reg;
        dt_next             = dt_reg;
        sum_next            = sum_reg;
        term_neg_next       = term_neg_reg;
        res_cmd_next        = res_cmd_reg;
        acc_next            = acc_reg;
        mcand_next          = mcand_reg;
        mplier_next         = mplier_reg;
        rem_next            = rem_reg;
        divisor_next        = divisor_reg;
        cnt_next            = cnt_reg;
        out_valid_next      = out_valid_reg && !out_ch.ready;
        out_cmd_next        = out_cmd_reg;
        out_to_next         = out_to_reg;

        // advance the serial unit
        if (is_mul)
        begin
            acc_next    = mul_sum;
            mcand_next  = {mcand_reg[94:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next    = cnt_reg + 7'd1;
        end
        else if (is_div)
        begin
            acc_next = div_q;
            rem_next = div_rem;
            cnt_next = cnt_reg + 7'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    meas_next = in_ch.measured_speed;
                    now_next  = in_ch.now_us;
                    if (in_ch.action == ACT_SET)
                    begin
                        target_next         = in_ch.target_value;
                        setpoint_stamp_next = in_ch.now_us;
                        update_stamp_next   = in_ch.now_us;
                        expired_next        = 1'b0;
                        term_neg_next       = in_ch.target_value[31] ^ ff_gain_reg[31];
                        acc_next            = '0;
                        mcand_next          = {64'd0, mag32(in_ch.target_value)};
                        mplier_next         = mag32(ff_gain_reg);
                        cnt_next            = '0;
                    end
                    else if (in_ch.action == ACT_CLEAR)
                    begin
                        last_error_next     = '0;
                        err_accum_next      = '0;
                        target_next         = '0;
                        ff_term_next        = '0;
                        setpoint_stamp_next = in_ch.now_us;
                        update_stamp_next   = in_ch.now_us;
                        expired_next        = 1'b0;
                    end
                end
            end
            ST_FF:
            begin
                if (unit_last)
                    ff_term_next = ff_sat;
            end
            ST_EVAL:
            begin
                if (timeout_hit)
                begin
                    // drop back to target zero and flag the expiry
                    last_error_next     = '0;
                    err_accum_next      = '0;
                    target_next         = '0;
                    ff_term_next        = '0;
                    setpoint_stamp_next = now_reg;
                    update_stamp_next   = now_reg;
                    expired_next        = 1'b1;
                    res_cmd_next        = last_command_reg;
                end
                else if (dt_now == 32'd0)
                begin
                    res_cmd_next = last_command_reg;
                end
                else
                begin
                    update_stamp_next = now_reg;
                    error_next        = err_now;
                    dt_next           = dt_now;
                    if (in_dead)
                    begin
                        last_command_next = '0;
                        res_cmd_next      = '0;
                    end
                    else
                    begin
                        term_neg_next = err_now[32] ^ prop_gain_reg[31];
                        acc_next      = '0;
                        mcand_next    = {63'd0, err_mag};
                        mplier_next   = mag32(prop_gain_reg);
                        cnt_next      = '0;
                    end
                end
            end
            ST_P:
            begin
                if (unit_last)
                begin
                    sum_next = apply_sign(mul_sum[79:16], term_neg_reg);
                    acc_next = '0;
                    cnt_next = '0;
                    if (deriv_gain_reg != 32'd0)
                    begin
                        term_neg_next = derr[33] ^ deriv_gain_reg[31];
                        mcand_next    = {62'd0, derr_mag};
                        mplier_next   = mag32(deriv_gain_reg);
                    end
                    else
                    begin
                        term_neg_next = err_accum_reg[31] ^ integral_gain_reg[31];
                        mcand_next    = {64'd0, mag32(err_accum_reg)};
                        mplier_next   = mag32(integral_gain_reg);
                    end
                end
            end
            ST_D1:
            begin
                if (unit_last)
                begin
                    acc_next    = '0;
                    mcand_next  = {32'd0, mul_sum[63:0]};
                    mplier_next = MICRO;
                    cnt_next    = '0;
                end
            end
            ST_D2:
            begin
                if (unit_last)
                begin
                    acc_next     = {16'd0, mul_sum[95:16]};
                    rem_next     = '0;
                    divisor_next = dt_reg;
                    cnt_next     = '0;
                end
            end
            ST_DDIV:
            begin
                if (unit_last)
                begin
                    sum_next        = sum_reg + apply_sign(div_term, term_neg_reg);
                    last_error_next = error_reg;
                    term_neg_next   = err_accum_reg[31] ^ integral_gain_reg[31];
                    acc_next        = '0;
                    mcand_next      = {64'd0, mag32(err_accum_reg)};
                    mplier_next     = mag32(integral_gain_reg);
                    cnt_next        = '0;
                end
            end
            ST_I1:
            begin
                if (unit_last)
                begin
                    acc_next    = '0;
                    mcand_next  = {32'd0, mul_sum[63:0]};
                    mplier_next = dt_reg;
                    cnt_next    = '0;
                end
            end
            ST_I2:
            begin
                if (unit_last)
                begin
                    acc_next     = {16'd0, mul_sum[95:16]};
                    rem_next     = '0;
                    divisor_next = MICRO;
                    cnt_next     = '0;
                end
            end
            ST_IDIV:
            begin
                if (unit_last)
                begin
                    sum_next       = sum_reg + apply_sign(div_term, term_neg_reg);
                    err_accum_next = acc_clamped[31:0];
                end
            end
            ST_CMD:
            begin
                last_command_next = cmd_final;
                res_cmd_next      = cmd_final;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = res_cmd_reg;
                    out_to_next    = expired_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            target_reg         <= '0;
            ff_term_reg        <= '0;
            err_accum_reg      <= '0;
            last_error_reg     <= '0;
            setpoint_stamp_reg <= '0;
            update_stamp_reg   <= '0;
            last_command_reg   <= '0;
            expired_reg        <= 1'b0;
            meas_reg           <= '0;
            now_reg            <= '0;
            error_reg          <= '0;
            dt_reg             <= '0;
            sum_reg            <= '0;
            term_neg_reg       <= 1'b0;
            res_cmd_reg        <= '0;
            acc_reg            <= '0;
            mcand_reg          <= '0;
            mplier_reg         <= '0;
            rem_reg            <= '0;
            divisor_reg        <= '0;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
            out_cmd_reg        <= '0;
            out_to_reg         <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            target_reg         <= target_next;
            ff_term_reg        <= ff_term_next;
            err_accum_reg      <= err_accum_next;
            last_error_reg     <= last_error_next;
            setpoint_stamp_reg <= setpoint_stamp_next;
            update_stamp_reg   <= update_stamp_next;
            last_command_reg   <= last_command_next;
            expired_reg        <= expired_next;
            meas_reg           <= meas_next;
            now_reg            <= now_next;
            error_reg          <= error_next;
            dt_reg             <= dt_next;
            sum_reg            <= sum_next;
            term_neg_reg       <= term_neg_next;
            res_cmd_reg        <= res_cmd_next;
            acc_reg            <= acc_next;
            mcand_reg          <= mcand_next;
            mplier_reg         <= mplier_next;
            rem_reg            <= rem_next;
            divisor_reg        <= divisor_next;
            cnt_reg            <= cnt_next;
            out_valid_reg      <= out_valid_next;
            out_cmd_reg        <= out_cmd_next;
            out_to_reg         <= out_to_next;
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ch.ready    = (state_reg == ST_IDLE);
        out_ch.valid   = out_valid_reg;
        out_ch.command = out_cmd_reg;
        out_ch.expired = out_to_reg;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        is_mul |-> cnt_reg <= MUL_LAST)
        else $error("multiplier count overran");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        is_div |-> divisor_reg != 32'd0)
        else $error("divide by zero in serial unit");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        is_div |-> rem_reg < {1'b0, divisor_reg})
        else $error("partial remainder not below divisor");

    a_accum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDIV && cnt_reg == DIV_LAST) |=>
        ($signed({err_accum_reg[31], err_accum_reg}) <= $signed({2'b0, sum_limit_reg})) &&
        ($signed({err_accum_reg[31], err_accum_reg}) >= -$signed({2'b0, sum_limit_reg})))
        else $error("integral accumulator outside its clamp");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not posted to output register");

endmodule

FILE: sim/speed_pid_with_timeout_core_tb.sv
// ----------------------------------------------------------------------------
// speed_pid_with_timeout_core_tb: self-checking bench for the speed PID core
// Drives set-target, compute, clear and unknown items through the input
// channel. The bench keeps its own model of the controller, which predicts
// each command and timeout flag, and checks every result transfer against it.
// The register set changes between phases while the core is idle. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module speed_pid_with_timeout_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spid_pkg::*;

    localparam logic [1:0]  ACT_UNKNOWN = 2'd3;
    localparam logic [63:0] CAP         = 64'h1000_0000_0000_0000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 240;
    localparam int          SETTLE      = 400;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] tgt;
        logic signed [31:0] meas;
        logic [31:0]        now;
    } pid_item_t;

    typedef struct {
        logic signed [15:0] cmd;
        logic               tmo;
    } drive_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spid_in_if  inb ();
    spid_out_if outb ();

    speed_pid_with_timeout_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (inb),
        .out_ch  (outb),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model copy of the registers
    logic signed [31:0] kp, ki, kd, kff;
    logic [30:0]        dband, slimit;
    logic signed [15:0] clo, chi;
    // model copy of the controller state
    logic signed [31:0] tgt_q, ff_q, accum_q;
    logic signed [32:0] lerr_q;
    logic [31:0]        sp_stamp, up_stamp;
    logic signed [15:0] lcmd_q;
    logic               expired_q;

    pid_item_t  pending_items[$];
    drive_cmd_t expected_cmds[$];
    pid_item_t  on_bus;
    pid_item_t  nxt;
    int         in_gap;
    int         out_gap;
    logic       calm;
    int         failures;
    int         n_cmds;
    int         n_timeouts;
    int         n_items;
    logic [31:0] clock_us;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // sign(x*y) * min(floor(|x*y| * z / c), 2^60); |x*y| wraps at 64 bits
    function automatic logic signed [63:0] scaled_term(input logic signed [63:0] x,
                                                       input logic signed [63:0] y,
                                                       input logic [63:0] z,
                                                       input logic [63:0] c);
        logic [63:0]  mx;
        logic [63:0]  my;
        logic [63:0]  p;
        logic [127:0] w;
        logic [127:0] zw;
        logic [127:0] cw;
        logic [63:0]  m;
        mx = x[63] ? -x : x;
        my = y[63] ? -y : y;
        p = mx * my;
        w = {64'd0, p};
        zw = {64'd0, z};
        cw = {64'd0, c};
        w = (w * zw) / cw;
        m = (w > {64'd0, CAP}) ? CAP : w[63:0];
        return (x[63] != y[63]) ? -m : m;
    endfunction

    task automatic load_target(input logic signed [31:0] t, input logic [31:0] now);
        logic signed [63:0] f;
        f = scaled_term(kff, t, 64'd1, 64'd65536);
        if (f > 64'sd2147483647)
            f = 64'sd2147483647;
        if (f < -64'sd2147483648)
            f = -64'sd2147483648;
        ff_q = f[31:0];
        tgt_q = t;
        sp_stamp = now;
        up_stamp = now;
        expired_q = 1'b0;
    endtask

    task automatic clear_history(input logic [31:0] now);
        lerr_q = '0;
        accum_q = '0;
        load_target(32'sd0, now);
    endtask

    task automatic pid_update(input pid_item_t it);
        logic [31:0]        dt;
        logic signed [63:0] err;
        logic signed [63:0] sum;
        logic signed [63:0] acc;
        logic signed [63:0] tmag;
        drive_cmd_t         r;
        if (!expired_q && (it.now - sp_stamp) > TIMEOUT_US)
        begin
            clear_history(it.now);
            expired_q = 1'b1;
            n_timeouts++;
        end
        dt = it.now - up_stamp;
        if (dt != 0)
        begin
            err = 64'(tgt_q) - 64'(it.meas);
            up_stamp = it.now;
            tmag = tgt_q[31] ? -64'(tgt_q) : 64'(tgt_q);
            if (tmag < 64'(dband))
                lcmd_q = '0;
            else
            begin
                sum = scaled_term(kp, err, 64'd1, 64'd65536);
                if (kd != 0)
                begin
                    sum += scaled_term(kd, err - 64'(lerr_q), 64'd1000000,
                                       64'(dt) * 64'd65536);
                    lerr_q = err[32:0];
                end
                if (ki != 0)
                begin
                    sum += scaled_term(ki, accum_q, 64'(dt), 64'd65536000000);
                    acc = 64'(accum_q) + err;
                    if (acc > $signed(64'(slimit)))
                        acc = 64'(slimit);
                    if (acc < -$signed(64'(slimit)))
                        acc = -$signed(64'(slimit));
                    accum_q = acc[31:0];
                end
                sum += 64'(ff_q);
                if (sum > 64'(chi) * 65536)
                    lcmd_q = chi;
                else if (sum < 64'(clo) * 65536)
                    lcmd_q = clo;
                else
                    lcmd_q = 16'(sum / 65536);
            end
        end
        r.cmd = lcmd_q;
        r.tmo = expired_q;
        expected_cmds.push_back(r);
    endtask

    task automatic predict(input pid_item_t it);
        case (it.act)
            ACT_SET:     load_target(it.tgt, it.now);
            ACT_CLEAR:   clear_history(it.now);
            ACT_COMPUTE: pid_update(it);
            default:     ;
        endcase
    endtask

    // input driver: hold an item until its transfer, then advance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (inb.valid && inb.ready)
            begin
                predict(on_bus);
                n_items++;
            end
            if (!inb.valid || inb.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    inb.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    on_bus = pending_items.pop_front();
                    inb.valid <= 1'b1;
                    inb.action <= on_bus.act;
                    inb.target_value <= on_bus.tgt;
                    inb.measured_speed <= on_bus.meas;
                    inb.now_us <= on_bus.now;
                    if (!calm && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 3);
                end
                else
                    inb.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        drive_cmd_t e;
        if (rst_n)
        begin
            if (outb.valid && outb.ready)
            begin
                n_cmds++;
                if (expected_cmds.size() == 0)
                begin
                    $error("unexpected result: command %0d expired %0b",
                           outb.command, outb.expired);
                    failures++;
                end
                else
                begin
                    e = expected_cmds.pop_front();
                    if (outb.command !== e.cmd)
                    begin
                        $error("command: expected %0d, got %0d", e.cmd, outb.command);
                        failures++;
                    end
                    if (outb.expired !== e.tmo)
                    begin
                        $error("expired: expected %0b, got %0b", e.tmo, outb.expired);
                        failures++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                outb.ready <= 1'b0;
            end
            else
            begin
                outb.ready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    out_gap = $urandom_range(1, 3);
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     kp = v;
            REG_INTEGRAL_GAIN: ki = v;
            REG_DERIV_GAIN:    kd = v;
            REG_FF_GAIN:       kff = v;
            REG_DEAD_BAND:     dband = v[30:0];
            REG_SUM_LIMIT:     slimit = v[30:0];
            REG_CMD_LOW:       clo = v[15:0];
            REG_CMD_HIGH:      chi = v[15:0];
            default:           ;
        endcase
    endtask

    // hold until every item has gone and every result arrived, then settle
    task automatic drain();
        int guard;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while ((pending_items.size() > 0 || inb.valid || expected_cmds.size() > 0)
               && guard < 2000000);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'd65536;
            4:       return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            5:       return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return $urandom();
        endcase
    endfunction

    task automatic random_config(input int ph);
        logic [31:0] lo;
        logic [31:0] hi;
        reg_write(REG_PROP_GAIN, pick_gain());
        reg_write(REG_INTEGRAL_GAIN, pick_gain());
        reg_write(REG_DERIV_GAIN, pick_gain());
        reg_write(REG_FF_GAIN, pick_gain());
        case ($urandom_range(0, 5))
            0:       reg_write(REG_DEAD_BAND, 32'h7FFF_FFFF);
            1, 2:    reg_write(REG_DEAD_BAND, 32'd0);
            3:       reg_write(REG_DEAD_BAND, $urandom());
            default: reg_write(REG_DEAD_BAND, $urandom_range(0, 1 << 18));
        endcase
        case ($urandom_range(0, 3))
            0:       reg_write(REG_SUM_LIMIT, 32'h7FFF_FFFF);
            1:       reg_write(REG_SUM_LIMIT, 32'd0);
            2:       reg_write(REG_SUM_LIMIT, $urandom());
            default: reg_write(REG_SUM_LIMIT, $urandom_range(0, 1 << 24));
        endcase
        case (ph % 4)
            0:
            begin
                lo = 32'hFFFF_8000;
                hi = 32'h0000_7FFF;
            end
            1:
            begin
                // inverted limits: the high test wins
                lo = $urandom_range(0, 1000);
                hi = 32'(-$signed($urandom_range(0, 1000)));
            end
            2:
            begin
                lo = $urandom();
                hi = $urandom();
            end
            default:
            begin
                lo = 32'(-$signed($urandom_range(1, 3000)));
                hi = $urandom_range(1, 3000);
            end
        endcase
        reg_write(REG_CMD_LOW, lo);
        reg_write(REG_CMD_HIGH, hi);
    endtask

    task automatic push_item(input logic [1:0] a, input logic signed [31:0] t,
                             input logic signed [31:0] m, input logic [31:0] now);
        nxt.act = a;
        nxt.tgt = t;
        nxt.meas = m;
        nxt.now = now;
        pending_items.push_back(nxt);
    endtask

    function automatic logic signed [31:0] pick_speed();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    task automatic random_item();
        int k;
        logic signed [31:0] m;
        k = $urandom_range(0, 99);
        case ($urandom_range(0, 39))
            0:       clock_us = $urandom();
            1, 2:    clock_us += $urandom_range(500001, 700000);
            3, 4:    ;
            5:       clock_us += $urandom();
            default: clock_us += $urandom_range(1, 3000);
        endcase
        m = ($urandom_range(0, 2) == 0) ? pick_speed()
            : 32'(tgt_q + $signed($urandom_range(0, 1 << 18)) - (1 << 17));
        if (k < 14)
            push_item(ACT_SET, pick_speed(), $urandom(), clock_us);
        else if (k < 20)
            push_item(ACT_CLEAR, $urandom(), $urandom(), clock_us);
        else if (k < 23)
            push_item(ACT_UNKNOWN, $urandom(), $urandom(), clock_us);
        else
            push_item(ACT_COMPUTE, $urandom(), m, clock_us);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        inb.valid = 1'b0;
        inb.action = ACT_SET;
        inb.target_value = '0;
        inb.measured_speed = '0;
        inb.now_us = '0;
        outb.ready = 1'b0;
        in_gap = 0;
        out_gap = 0;
        calm = 1'b0;
        failures = 0;
        n_cmds = 0;
        n_timeouts = 0;
        n_items = 0;
        kp = 32'sd65536;
        ki = '0;
        kd = '0;
        kff = '0;
        dband = '0;
        slimit = '0;
        clo = -16'sd255;
        chi = 16'sd255;
        tgt_q = '0;
        ff_q = '0;
        accum_q = '0;
        lerr_q = '0;
        sp_stamp = '0;
        up_stamp = '0;
        lcmd_q = '0;
        expired_q = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // a few items on the reset register values
        push_item(ACT_SET, 32'sd3 <<< 16, 32'sd0, 32'd100);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd1 <<< 16, 32'd200);
        push_item(ACT_COMPUTE, 32'sd0, 32'sh8000_0000, 32'd300);
        drain();

        reg_write(REG_PROP_GAIN, 32'd131072);
        reg_write(REG_INTEGRAL_GAIN, 32'd32768);
        reg_write(REG_DERIV_GAIN, 32'd655);
        reg_write(REG_FF_GAIN, 32'd65536);
        reg_write(REG_DEAD_BAND, 32'd32768);
        reg_write(REG_SUM_LIMIT, 32'h0010_0000);
        reg_write(REG_CMD_LOW, 32'hFFFF_FF01);
        reg_write(REG_CMD_HIGH, 32'd255);

        push_item(ACT_SET, 32'sh7FFF_FFFF, 32'sd0, 32'd1000);
        push_item(ACT_COMPUTE, 32'sd0, 32'sh8000_0000, 32'd1100);
        // zero time step repeats the last command
        push_item(ACT_COMPUTE, 32'sd0, 32'sd0, 32'd1100);
        push_item(ACT_COMPUTE, 32'sd0, 32'sh7FFF_FFFF, 32'd1101);
        push_item(ACT_SET, 32'sh8000_0000, 32'sd0, 32'd1200);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd0, 32'd1300);
        push_item(ACT_COMPUTE, 32'sd0, 32'sh7FFF_FFFF, 32'd2300);
        // target inside the dead band
        push_item(ACT_SET, 32'sd256, 32'sd0, 32'd2400);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd12345, 32'd2500);
        push_item(ACT_UNKNOWN, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF);
        push_item(ACT_CLEAR, 32'sd0, 32'sd0, 32'd2600);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd0, 32'd2700);
        // long silence expires the target, then the flag stays set
        push_item(ACT_SET, 32'sd5 <<< 16, 32'sd0, 32'd3000);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd1 <<< 16, 32'd603001);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd1 <<< 16, 32'd1203010);
        // timer wrap
        push_item(ACT_SET, 32'sd10 <<< 16, 32'sd0, 32'hFFFF_FF00);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd2 <<< 16, 32'h0000_0050);
        push_item(ACT_SET, 32'sd1 <<< 16, 32'sd0, 32'h0000_0100);
        push_item(ACT_COMPUTE, 32'sd0, 32'sd0, 32'h0000_0200);
        drain();

        clock_us = 32'h0000_0200;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_config(ph);
            if (ph == PHASES - 1)
                calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
            drain();
        end

        $display("%0d items sent, %0d commands checked, %0d timeouts predicted",
                 n_items, n_cmds, n_timeouts);
        $display("%0d register settings, gain and limit extremes included", PHASES + 1);
        if (failures == 0 && expected_cmds.size() == 0)
            $display("speed_pid_with_timeout_core_tb: PASS");
        else
            $display("speed_pid_with_timeout_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("speed_pid_with_timeout_core_tb: FAIL");
        $finish;
    end

endmodule
